[rtl/median_filter_2d_replicate_unit_assert.svh]
// Assertion macros for the median filter checker
`ifndef MEDIAN_FILTER_2D_REPLICATE_UNIT_ASSERT_SVH
`define MEDIAN_FILTER_2D_REPLICATE_UNIT_ASSERT_SVH

// clocked, disabled in reset
`define MF2R_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("median filter check failed");

// implication form
`define MF2R_ASSERT_IMP(lbl, ante, cons) \
    `MF2R_ASSERT(lbl, (ante) |-> (cons))

`endif

[rtl/mf2r_pkg.sv]
`timescale 1ns / 1ps
package mf2r_pkg;
    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HALF_KERNEL = 3;
    localparam int SAMPLE_BITS     = 8;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int LINES           = 2 * MAX_HALF_KERNEL + 2;
    localparam int WIN_SIDE        = 2 * MAX_HALF_KERNEL + 1;
    localparam int WIN_MAX         = WIN_SIDE * WIN_SIDE;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(HEIGHT_LIMIT);
    localparam int LINE_BITS       = $clog2(LINES);
    localparam int ADDR_BITS       = LINE_BITS + COL_BITS;
    localparam int WIN_IDX_BITS    = $clog2(WIN_MAX);

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_HALF_KERNEL_X = 2'd2;
    localparam logic [1:0] REG_HALF_KERNEL_Y = 2'd3;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                   command;
        logic [SAMPLE_BITS-1:0] sample;
    } mf2r_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered_sample;
        logic                   last_in_frame;
    } mf2r_out_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] val;
        logic                   valid;
        logic                   keep;
    } mf2r_link_t;
endpackage

[rtl/mf2r_cell.sv]
`timescale 1ns / 1ps
module mf2r_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            clr,
    input  logic                            ins,
    input  logic [mf2r_pkg::SAMPLE_BITS-1:0] v,
    input  mf2r_pkg::mf2r_link_t            prev_link,
    output mf2r_pkg::mf2r_link_t            link
);
    import mf2r_pkg::*;

    logic [SAMPLE_BITS-1:0] val_reg;
    logic                   valid_reg;
    logic                   keep;

    assign keep = valid_reg && (val_reg <= v);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (clr) begin
            valid_reg <= 1'b0;
        end else if (ins && !keep) begin
            valid_reg <= valid_reg | prev_link.valid;
            val_reg   <= prev_link.keep ? v : prev_link.val;
        end
    end

    assign link.val   = val_reg;
    assign link.valid = valid_reg;
    assign link.keep  = keep;
endmodule

[rtl/mf2r_sorter.sv]
`timescale 1ns / 1ps
module mf2r_sorter (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   clr,
    input  logic                                                   ins,
    input  logic [mf2r_pkg::SAMPLE_BITS-1:0]                        v,
    output logic [mf2r_pkg::WIN_MAX-1:0][mf2r_pkg::SAMPLE_BITS-1:0] vals
);
    import mf2r_pkg::*;

    mf2r_link_t links [0:WIN_MAX];

    assign links[0] = '{val: '0, valid: 1'b1, keep: 1'b1};

    for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
        mf2r_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clr       (clr),
            .ins       (ins),
            .v         (v),
            .prev_link (links[i]),
            .link      (links[i+1])
        );
        assign vals[i] = links[i+1].val;
    end
endmodule

[rtl/median_filter_2d_replicate_unit.sv]
`timescale 1ns / 1ps
// Streaming 2-D median filter, replicate border, one 8-bit image plane.
// s_ channel: items {command, sample}; push (0) stores a raster-order
// sample, drain (1) fetches one pending output once the frame is in.
// m_ channel: items {filtered_sample, last_in_frame}, raster order.
// cfg channel: register index and data (width, height, radius x, y);
// any write restarts the frame. cfg_ready is high only while the block is
// idle and no input item is offered.
// An item that produces no output leaves the block idle. For one that
// does, with n = (2*hx+1)*(2*hy+1), the n window samples are read from
// the line store one per cycle and fed into a chain of insertion-sort
// cells; a flush state and a done state follow, and the median then
// loads into the output register. s_ready drops while a window is sorted.
// A finished output waits in the output register; further items are
// still taken, but the next output cannot load until it is taken, so a
// stalled receiver holds the block after at most one more window.
// Reset: synchronous, active low; counters cleared, registers to
// 640 x 480, radius 1 x 1. Line store contents are not cleared.
module median_filter_2d_replicate_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mf2r_pkg::mf2r_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mf2r_pkg::mf2r_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);
    import mf2r_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_DONE} state_t;

    state_t                  state_reg;
    logic [10:0]             width_reg;
    logic [12:0]             height_reg;
    logic [1:0]              hkx_reg, hky_reg;
    logic [ROW_BITS-1:0]     in_row_reg, out_row_reg;
    logic [COL_BITS-1:0]     in_col_reg, out_col_reg;
    logic [2:0]              ix_reg, iy_reg;
    logic [4:0]              med_idx_reg;
    logic [SAMPLE_BITS-1:0]  rdata_reg;
    logic                    rvalid_reg;
    mf2r_out_t               m_data_reg;
    logic                    m_valid_reg;

    logic [SAMPLE_BITS-1:0]  line_store [0:LINES*MAX_WIDTH-1];

    logic                    accept, cfg_we, pending, out_ok, start, wr_en, rd_en, load;
    logic [12:0]             need_r, need_r_c;
    logic [10:0]             need_c, need_c_c;
    logic [ROW_BITS-1:0]     in_row_next, out_row_next;
    logic [COL_BITS-1:0]     in_col_next, out_col_next;
    logic [12:0]             r_sum, r_sub;
    logic [10:0]             c_sum, c_sub;
    logic [ROW_BITS-1:0]     rd_row;
    logic [COL_BITS-1:0]     rd_col;
    logic [ADDR_BITS-1:0]    wr_addr, rd_addr;
    logic [5:0]              win_n;
    logic                    win_last, last_px;
    logic [WIN_MAX-1:0][SAMPLE_BITS-1:0] vals;
    logic [10:0]             width_next;
    logic [12:0]             height_next;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign pending = (in_row_reg == '0) && (in_col_reg == '0) &&
                     ((out_row_reg != '0) || (out_col_reg != '0));

    always_comb begin
        need_r   = {1'b0, out_row_reg} + {11'b0, hky_reg};
        need_r_c = (need_r >= height_reg) ? height_reg - 13'd1 : need_r;
        need_c   = {1'b0, out_col_reg} + {9'b0, hkx_reg};
        need_c_c = (need_c >= width_reg) ? width_reg - 11'd1 : need_c;
        out_ok   = (need_r_c < {1'b0, in_row_reg}) ||
                   ((need_r_c == {1'b0, in_row_reg}) && (need_c_c <= {1'b0, in_col_reg}));
    end

    assign start = accept && ((s_data.command == CMD_DRAIN) ? pending : (!pending && out_ok));
    assign wr_en = accept && (s_data.command == CMD_PUSH) && !pending;

    always_comb begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg + 1'b1;
        if ({1'b0, in_col_reg} + 11'd1 >= width_reg) begin
            in_col_next = '0;
            in_row_next = in_row_reg + 1'b1;
            if ({1'b0, in_row_reg} + 13'd1 >= height_reg) begin
                in_row_next = '0;
            end
        end
        out_row_next = out_row_reg;
        out_col_next = out_col_reg + 1'b1;
        if ({1'b0, out_col_reg} + 11'd1 >= width_reg) begin
            out_col_next = '0;
            out_row_next = out_row_reg + 1'b1;
            if ({1'b0, out_row_reg} + 13'd1 >= height_reg) begin
                out_row_next = '0;
            end
        end
    end

    // clamped window coordinate of the current read
    always_comb begin
        r_sum = {1'b0, out_row_reg} + {10'b0, iy_reg};
        r_sub = r_sum - {11'b0, hky_reg};
        if (r_sum < {11'b0, hky_reg}) begin
            rd_row = '0;
        end else if (r_sub >= height_reg) begin
            rd_row = ROW_BITS'(height_reg - 13'd1);
        end else begin
            rd_row = r_sub[ROW_BITS-1:0];
        end
        c_sum = {1'b0, out_col_reg} + {8'b0, ix_reg};
        c_sub = c_sum - {9'b0, hkx_reg};
        if (c_sum < {9'b0, hkx_reg}) begin
            rd_col = '0;
        end else if (c_sub >= width_reg) begin
            rd_col = COL_BITS'(width_reg - 11'd1);
        end else begin
            rd_col = c_sub[COL_BITS-1:0];
        end
    end

    assign rd_addr  = {rd_row[LINE_BITS-1:0], rd_col};
    assign wr_addr  = {in_row_reg[LINE_BITS-1:0], in_col_reg};
    assign rd_en    = (state_reg == ST_RUN);
    assign win_last = (ix_reg == {hkx_reg, 1'b0}) && (iy_reg == {hky_reg, 1'b0});
    assign win_n    = {3'b0, hkx_reg, 1'b1} * {3'b0, hky_reg, 1'b1};
    assign last_px  = ({1'b0, out_row_reg} == height_reg - 13'd1) &&
                      ({1'b0, out_col_reg} == width_reg - 11'd1);
    assign load     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store[wr_addr] <= s_data.sample;
        end
        if (rd_en) begin
            rdata_reg <= line_store[rd_addr];
        end
    end

    mf2r_sorter u_sorter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (start),
        .ins     (rvalid_reg),
        .v       (rdata_reg),
        .vals    (vals)
    );

    always_comb begin
        width_next = cfg_data[10:0];
        if (width_next == '0) begin
            width_next = 11'd1;
        end else if (width_next > 11'(MAX_WIDTH)) begin
            width_next = 11'(MAX_WIDTH);
        end
        height_next = cfg_data;
        if (height_next == '0) begin
            height_next = 13'd1;
        end else if (height_next > 13'(HEIGHT_LIMIT)) begin
            height_next = 13'(HEIGHT_LIMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= 11'd640;
            height_reg  <= 13'd480;
            hkx_reg     <= 2'd1;
            hky_reg     <= 2'd1;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rvalid_reg <= rd_en;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  <= width_next;
                    REG_IMAGE_HEIGHT:  height_reg <= height_next;
                    REG_HALF_KERNEL_X: hkx_reg    <= cfg_data[1:0];
                    REG_HALF_KERNEL_Y: hky_reg    <= cfg_data[1:0];
                    default: ;
                endcase
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
            end
            if (wr_en) begin
                in_row_reg <= in_row_next;
                in_col_reg <= in_col_next;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= '{filtered_sample: vals[WIN_IDX_BITS'(med_idx_reg)],
                                 last_in_frame: last_px};
                out_row_reg <= out_row_next;
                out_col_reg <= out_col_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        ix_reg      <= '0;
                        iy_reg      <= '0;
                        med_idx_reg <= win_n[5:1];
                        state_reg   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (win_last) begin
                        state_reg <= ST_FLUSH;
                    end else if (ix_reg == {hkx_reg, 1'b0}) begin
                        ix_reg <= '0;
                        iy_reg <= iy_reg + 3'd1;
                    end else begin
                        ix_reg <= ix_reg + 3'd1;
                    end
                end
                ST_FLUSH: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

[rtl/mf2r_checker.sv]
`timescale 1ns / 1ps
`include "median_filter_2d_replicate_unit_assert.svh"
module mf2r_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mf2r_pkg::mf2r_out_t m_data
);
    import mf2r_pkg::*;

    `MF2R_ASSERT(a_m_hold, m_valid && !m_ready |=> m_valid)
    `MF2R_ASSERT(a_m_stable, m_valid && !m_ready |=> $stable(m_data))
    `MF2R_ASSERT_IMP(a_load_busy, $rose(m_valid), !$past(s_ready))
    `MF2R_ASSERT(a_no_instant, s_valid && s_ready |=> !$rose(m_valid))
endmodule

bind median_filter_2d_replicate_unit mf2r_checker u_mf2r_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
